// ===== design/bqc_pkg.sv =====
// bqc_pkg: types, codes and sizes shared by the quadratic calibration block
// depends on nothing; imported by every design file and the checker
package bqc_pkg;

  localparam int NUM_CHIPS    = 4;
  localparam int NUM_CHANNELS = 8;
  localparam int TABLE_DEPTH  = NUM_CHIPS * NUM_CHANNELS;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);

  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] Q16_ONE = 32'sd1 <<< FRAC_BITS;

  // shared multiplier: 33-bit signed operands; unsigned ones are zero-extended to stay positive
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT  = 1'd1;

  localparam logic [19:0] SCALE_FACTOR_RESET = 20'd9375;
  localparam logic [4:0]  SCALE_SHIFT_RESET  = 5'd0;

  localparam logic [2:0] FUNC_APPLY    = 3'd0;
  localparam logic [2:0] FUNC_SET_COEF = 3'd1;
  localparam logic [2:0] FUNC_SET_OFF  = 3'd2;
  localparam logic [2:0] FUNC_ENABLE   = 3'd3;
  localparam logic [2:0] FUNC_DISABLE  = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         chip;
    logic [2:0]         channel;
    logic signed [23:0] sample;
    logic signed [31:0] const_term;
    logic signed [31:0] linear_term;
    logic signed [31:0] square_term;
    logic signed [23:0] zero_level;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               calibrated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } coef_t;

  // one table access, issued on the beat that accepts an item
  typedef struct packed {
    logic               rd_en;
    logic               wr_coef;
    logic               wr_off;
    logic               set_en;
    logic               clr_en;
    logic [IDX_W-1:0]   idx;
    coef_t              coef;
    logic signed [23:0] offset;
  } tbl_req_t;

  typedef struct packed {
    coef_t              coef;
    logic signed [23:0] offset;
    logic               enable;
  } tbl_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_SCALE,
    ST_SHIFT,
    ST_SQUARE,
    ST_LIN,
    ST_SQLO,
    ST_SQHI,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

// ===== design/bqc_table.sv =====
// bqc_table: per-entry calibration storage, coefficient and offset rams
// plus valid and enable flops; depends on bqc_pkg
module bqc_table import bqc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  tbl_req_t   req,
  output tbl_entry_t entry
);

  coef_t              coef_mem [TABLE_DEPTH];
  logic signed [23:0] off_mem  [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] coef_vld;
  logic [TABLE_DEPTH-1:0] off_vld;
  logic [TABLE_DEPTH-1:0] en;

  coef_t              coef_q;
  logic signed [23:0] off_q;
  logic               coef_vld_q;
  logic               off_vld_q;
  logic               en_q;

  // writes and reads come from different items, never the same beat
  always_ff @(posedge clk) begin
    if (req.wr_coef) begin
      coef_mem[req.idx] <= req.coef;
    end
    if (req.wr_off) begin
      off_mem[req.idx] <= req.offset;
    end
    if (req.rd_en) begin
      coef_q <= coef_mem[req.idx];
      off_q  <= off_mem[req.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld   <= '0;
      off_vld    <= '0;
      en         <= '0;
      coef_vld_q <= 1'b0;
      off_vld_q  <= 1'b0;
      en_q       <= 1'b0;
    end else begin
      if (req.wr_coef) begin
        coef_vld[req.idx] <= 1'b1;
      end
      if (req.wr_off) begin
        off_vld[req.idx] <= 1'b1;
      end
      if (req.wr_coef || req.set_en) begin
        en[req.idx] <= 1'b1;
      end else if (req.clr_en) begin
        en[req.idx] <= 1'b0;
      end
      if (req.rd_en) begin
        coef_vld_q <= coef_vld[req.idx];
        off_vld_q  <= off_vld[req.idx];
        en_q       <= en[req.idx];
      end
    end
  end

  // unwritten entries read as passthrough
  always_comb begin
    entry.coef.a0 = coef_vld_q ? coef_q.a0 : '0;
    entry.coef.a1 = coef_vld_q ? coef_q.a1 : Q16_ONE;
    entry.coef.a2 = coef_vld_q ? coef_q.a2 : '0;
    entry.offset  = off_vld_q ? off_q : '0;
    entry.enable  = en_q;
  end

endmodule

// ===== design/bridge_quadratic_calibration.sv =====
// bridge_quadratic_calibration: top level, sequencer, shared multiplier and
// output register; depends on bqc_pkg and bqc_table
//
// Input channel in_valid/in_ready/in_data carries one item: func selects
// apply, set coefficients (also enables), set offset, enable or disable for
// the entry chip*NUM_CHANNELS+channel. Every item gives one beat on
// out_valid/out_ready/out_data: the Q16.16 value and a calibrated flag,
// both zero for items that only edit the table.
// Config port cfg_we/cfg_index/cfg_data writes scale_factor or scale_shift,
// one per write; write only while no item is in flight.
// One item is worked at a time, in_ready is high only in idle. An enabled
// apply goes through table read, offset subtract, then scale, x*x, a1*x and
// a2 times both halves of x*x through a single 33x33 multiplier; a disabled
// apply stops after scale and shift, and a table edit goes straight to the
// output register.
// The output register holds a stalled result; the next item is accepted
// while it waits, and its result is held in the sequencer until the slot frees.
// Reset clears the table to passthrough at once (valid flops, no sweep) and
// drops out_valid.
module bridge_quadratic_calibration import bqc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [19:0] scale_factor;
  logic [4:0]  scale_shift;

  tbl_req_t   tbl_req;
  tbl_entry_t entry;

  logic             accept;
  logic             idx_ok;
  logic [IDX_W-1:0] idx;
  logic             ok_q;
  logic             use_poly;
  logic             out_load;

  logic signed [23:0]       sample_q;
  logic signed [24:0]       counts_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] p_q;
  logic signed [PROD_W-1:0] shifted;
  logic signed [31:0]       x_q;
  logic [46:0]              sq_q;
  logic signed [31:0]       acc_q;
  logic signed [31:0]       res_value;
  logic                     res_cal;
  logic signed [23:0]       off_sel;

  bqc_table u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tbl_req),
    .entry (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_FACTOR_RESET;
      scale_shift  <= SCALE_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE_FACTOR: scale_factor <= cfg_data[19:0];
        CFG_SCALE_SHIFT:  scale_shift  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;
  assign idx_ok = (int'(in_data.chip) < NUM_CHIPS) && (int'(in_data.channel) < NUM_CHANNELS);
  assign idx    = idx_ok ? IDX_W'(int'(in_data.chip) * NUM_CHANNELS + int'(in_data.channel))
                         : '0;
  assign use_poly = ok_q && entry.enable;

  always_comb begin
    tbl_req.rd_en   = accept && (in_data.func == FUNC_APPLY);
    tbl_req.wr_coef = accept && idx_ok && (in_data.func == FUNC_SET_COEF);
    tbl_req.wr_off  = accept && idx_ok && (in_data.func == FUNC_SET_OFF);
    tbl_req.set_en  = accept && idx_ok && (in_data.func == FUNC_ENABLE);
    tbl_req.clr_en  = accept && idx_ok && (in_data.func == FUNC_DISABLE);
    tbl_req.idx     = idx;
    tbl_req.coef.a0 = in_data.const_term;
    tbl_req.coef.a1 = in_data.linear_term;
    tbl_req.coef.a2 = in_data.square_term;
    tbl_req.offset  = in_data.zero_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.func == FUNC_APPLY) ? ST_OFFSET : ST_DONE;
        end
      end
      ST_OFFSET: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SHIFT;
      ST_SHIFT:  state_next = use_poly ? ST_SQUARE : ST_DONE;
      ST_SQUARE: state_next = ST_LIN;
      ST_LIN:    state_next = ST_SQLO;
      ST_SQLO:   state_next = ST_SQHI;
      ST_SQHI:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_SCALE: begin
        mul_a = {{(MUL_W-25){counts_q[24]}}, counts_q};
        mul_b = {{(MUL_W-20){1'b0}}, scale_factor};
      end
      ST_SQUARE: begin
        mul_a = {x_q[31], x_q};
        mul_b = {x_q[31], x_q};
      end
      ST_LIN: begin
        mul_a = {entry.coef.a1[31], entry.coef.a1};
        mul_b = {x_q[31], x_q};
      end
      ST_SQLO: begin
        mul_a = {entry.coef.a2[31], entry.coef.a2};
        mul_b = {{(MUL_W-24){1'b0}}, sq_q[23:0]};
      end
      ST_SQHI: begin
        mul_a = {entry.coef.a2[31], entry.coef.a2};
        mul_b = {{(MUL_W-23){1'b0}}, sq_q[46:24]};
      end
      default: ;
    endcase
  end

  // out-of-range entries apply no offset
  assign off_sel = ok_q ? entry.offset : '0;
  assign shifted = p_q >>> scale_shift;

  always_ff @(posedge clk) begin
    p_q <= mul_a * mul_b;
    if (accept) begin
      sample_q  <= in_data.sample;
      ok_q      <= idx_ok;
      res_value <= '0;
      res_cal   <= 1'b0;
    end
    unique case (state)
      ST_OFFSET: counts_q <= {sample_q[23], sample_q} - {off_sel[23], off_sel};
      ST_SHIFT: begin
        x_q <= shifted[31:0];
        if (!use_poly) begin
          res_value <= shifted[31:0];
        end
      end
      ST_LIN:  sq_q  <= p_q[62:16];
      ST_SQLO: acc_q <= entry.coef.a0 + p_q[47:16];
      ST_SQHI: acc_q <= acc_q + p_q[47:16];
      // high half of x*x sits 24 bits up, so only its low product bits land
      ST_SUM: begin
        res_value <= acc_q + {p_q[23:0], 8'b0};
        res_cal   <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.value      <= res_value;
      out_data.calibrated <= res_cal;
    end
  end

endmodule

// ===== design/bqc_check.sv =====
// bqc_check: port-level assertions for the calibration block, bound to
// the top level; depends on bqc_pkg
module bqc_check import bqc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a result that is stalled stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one item at a time: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // a fresh item cannot already have a result waiting behind it
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared the beat after accept");

endmodule

bind bridge_quadratic_calibration bqc_check u_bqc_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
